FILE: rtl/pua_pkg.sv
// Shared types, constants and fixed-point helpers for the particle update block.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none
package pua_pkg;

	localparam int MAX_ATLAS_ROWS = 16;

	// clamped row count, stage count, stage index, row/column widths
	localparam int NW = $clog2(MAX_ATLAS_ROWS + 1);
	localparam int STG_W = $clog2(MAX_ATLAS_ROWS * MAX_ATLAS_ROWS + 1);
	localparam int IDX_W = (MAX_ATLAS_ROWS > 1) ?
		$clog2(MAX_ATLAS_ROWS * MAX_ATLAS_ROWS) : 1;
	localparam int RW = (MAX_ATLAS_ROWS > 1) ? $clog2(MAX_ATLAS_ROWS) : 1;

	// progress quotient: stage index above a 16-bit fraction
	localparam int Q_W = IDX_W + 16;

	// offset division: 16 quotient bits, OFF_STEPS bits per stage
	localparam int OFF_STEPS = 4;
	localparam int OFF_STG = 16 / OFF_STEPS;

	localparam int MOT_LAT = 13;
	localparam int ATL_LAT = 1 + Q_W + 1 + OFF_STG;
	localparam int DEPTH = ATL_LAT;
	localparam int PAD = ATL_LAT - MOT_LAT;

	// -9.8 in Q16.16
	localparam logic signed [21:0] NEG_GRAVITY = -22'sd642253;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELTA_TIME = 3'd0,
		REG_CAMERA_X   = 3'd1,
		REG_CAMERA_Y   = 3'd2,
		REG_CAMERA_Z   = 3'd3,
		REG_ATLAS_ROWS = 3'd4
	} pua_reg_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] gravity_effect;
		logic [31:0]        life_length;
		logic [31:0]        elapsed_time;
	} pua_in_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic signed [31:0] new_vel_y;
		logic [31:0]        new_elapsed;
		logic               alive;
		logic [63:0]        distance_sq;
		logic [15:0]        tex1_u;
		logic [15:0]        tex1_v;
		logic [15:0]        tex2_u;
		logic [15:0]        tex2_v;
		logic [15:0]        blend;
	} pua_out_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic signed [31:0] new_vel_y;
		logic [63:0]        distance_sq;
	} pua_mot_t;

	typedef struct packed {
		logic [31:0] new_elapsed;
		logic        alive;
		logic [15:0] tex1_u;
		logic [15:0] tex1_v;
		logic [15:0] tex2_u;
		logic [15:0] tex2_v;
		logic [15:0] blend;
	} pua_atl_t;

	// shift a product right by 16, rounding half away from zero
	function automatic logic signed [47:0] rnd16(input logic signed [63:0] v);
		logic [63:0] m;
		m = v[63] ? 64'(-v) : 64'(v);
		m = (m + 64'h8000) >> 16;
		return v[63] ? -$signed(m[47:0]) : $signed(m[47:0]);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		if (v > 49'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -49'sd2147483648) return 32'sh80000000;
		return $signed(v[31:0]);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/pua_if.sv
// Valid/ready channel interfaces: particle items, result items, register writes.
// Depends on pua_pkg for the payload types.
`default_nettype none
interface pua_item_if import pua_pkg::*; ();
	logic    valid;
	logic    ready;
	pua_in_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pua_result_if import pua_pkg::*; ();
	logic     valid;
	logic     ready;
	pua_out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pua_cfg_if import pua_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/pua_motion.sv
// Kinematics pipeline: gravity on vertical velocity, position step, camera distance.
// All stages advance under a shared advance enable; uses pua_pkg.
`default_nettype none
module pua_motion import pua_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [31:0]        dt,
	input  wire logic signed [31:0] cam_x,
	input  wire logic signed [31:0] cam_y,
	input  wire logic signed [31:0] cam_z,
	input  wire pua_in_t            item,
	output pua_mot_t                res
);

	logic signed [32:0] dt33;
	logic signed [65:0] pg_c, pvx_c, pvz_c, pny_c;
	logic signed [55:0] pdv_c;
	logic signed [32:0] dx_c, dy_c, dz_c;
	logic [64:0]        s01_c, s_c;

	logic signed [63:0] pg_s1, pvx_s1, pvz_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1, vy_s1;
	logic signed [47:0] rg_s2, rx_s2, rz_s2;
	logic signed [31:0] px_s2, py_s2, pz_s2, vy_s2;
	logic signed [33:0] gdt_s3;
	logic signed [31:0] nx_s3, nz_s3, py_s3, vy_s3;
	logic signed [55:0] pdv_s4;
	logic signed [31:0] nx_s4, nz_s4, py_s4, vy_s4;
	logic signed [47:0] dv_s5;
	logic signed [31:0] nx_s5, nz_s5, py_s5, vy_s5;
	logic signed [31:0] nvy_s6, nx_s6, nz_s6, py_s6;
	logic signed [63:0] pny_s7;
	logic signed [31:0] nvy_s7, nx_s7, nz_s7, py_s7;
	logic signed [47:0] ry_s8;
	logic signed [31:0] nvy_s8, nx_s8, nz_s8, py_s8;
	pua_mot_t           r_s9, r_s10, r_s11, r_s12, r_s13;
	logic [31:0]        mx_s10, my_s10, mz_s10;
	logic [63:0]        sqx_s11, sqy_s11, sqz_s11;
	logic [63:0]        s01_s12, sqz_s12;

	assign dt33  = $signed({1'b0, dt});
	assign pg_c  = $signed({item.gravity_effect[31], item.gravity_effect}) * dt33;
	assign pvx_c = $signed({item.vel_x[31], item.vel_x}) * dt33;
	assign pvz_c = $signed({item.vel_z[31], item.vel_z}) * dt33;
	assign pdv_c = gdt_s3 * NEG_GRAVITY;
	assign pny_c = $signed({nvy_s6[31], nvy_s6}) * dt33;
	assign dx_c  = 33'(cam_x) - 33'(r_s9.new_pos_x);
	assign dy_c  = 33'(cam_y) - 33'(r_s9.new_pos_y);
	assign dz_c  = 33'(cam_z) - 33'(r_s9.new_pos_z);
	assign s01_c = {1'b0, sqx_s11} + {1'b0, sqy_s11};
	assign s_c   = {1'b0, s01_s12} + {1'b0, sqz_s12};

	always_ff @(posedge clk) begin
		if (en) begin
			pg_s1  <= pg_c[63:0];
			pvx_s1 <= pvx_c[63:0];
			pvz_s1 <= pvz_c[63:0];
			px_s1  <= item.pos_x;
			py_s1  <= item.pos_y;
			pz_s1  <= item.pos_z;
			vy_s1  <= item.vel_y;

			rg_s2 <= rnd16(pg_s1);
			rx_s2 <= rnd16(pvx_s1);
			rz_s2 <= rnd16(pvz_s1);
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			pz_s2 <= pz_s1;
			vy_s2 <= vy_s1;

			// clamp gravity step to +-2^32; past that the velocity saturates anyway
			if (rg_s2 > 48'sd4294967296)
				gdt_s3 <= 34'sd4294967296;
			else if (rg_s2 < -48'sd4294967296)
				gdt_s3 <= -34'sd4294967296;
			else
				gdt_s3 <= 34'(rg_s2);
			nx_s3 <= sat32(49'(px_s2) + 49'(rx_s2));
			nz_s3 <= sat32(49'(pz_s2) + 49'(rz_s2));
			py_s3 <= py_s2;
			vy_s3 <= vy_s2;

			pdv_s4 <= pdv_c;
			nx_s4  <= nx_s3;
			nz_s4  <= nz_s3;
			py_s4  <= py_s3;
			vy_s4  <= vy_s3;

			dv_s5 <= rnd16(64'(pdv_s4));
			nx_s5 <= nx_s4;
			nz_s5 <= nz_s4;
			py_s5 <= py_s4;
			vy_s5 <= vy_s4;

			nvy_s6 <= sat32(49'(vy_s5) + 49'(dv_s5));
			nx_s6  <= nx_s5;
			nz_s6  <= nz_s5;
			py_s6  <= py_s5;

			pny_s7 <= pny_c[63:0];
			nvy_s7 <= nvy_s6;
			nx_s7  <= nx_s6;
			nz_s7  <= nz_s6;
			py_s7  <= py_s6;

			ry_s8  <= rnd16(pny_s7);
			nvy_s8 <= nvy_s7;
			nx_s8  <= nx_s7;
			nz_s8  <= nz_s7;
			py_s8  <= py_s7;

			r_s9.new_pos_x   <= nx_s8;
			r_s9.new_pos_y   <= sat32(49'(py_s8) + 49'(ry_s8));
			r_s9.new_pos_z   <= nz_s8;
			r_s9.new_vel_y   <= nvy_s8;
			r_s9.distance_sq <= '0;

			mx_s10 <= dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
			my_s10 <= dy_c[32] ? 32'(-dy_c) : dy_c[31:0];
			mz_s10 <= dz_c[32] ? 32'(-dz_c) : dz_c[31:0];
			r_s10  <= r_s9;

			sqx_s11 <= mx_s10 * mx_s10;
			sqy_s11 <= my_s10 * my_s10;
			sqz_s11 <= mz_s10 * mz_s10;
			r_s11   <= r_s10;

			s01_s12 <= s01_c[64] ? '1 : s01_c[63:0];
			sqz_s12 <= sqz_s11;
			r_s12   <= r_s11;

			r_s13.new_pos_x   <= r_s12.new_pos_x;
			r_s13.new_pos_y   <= r_s12.new_pos_y;
			r_s13.new_pos_z   <= r_s12.new_pos_z;
			r_s13.new_vel_y   <= r_s12.new_vel_y;
			r_s13.distance_sq <= s_c[64] ? '1 : s_c[63:0];
		end
	end

	assign res = r_s13;

endmodule
`default_nettype wire

FILE: rtl/pua_atlas.sv
// Atlas staging pipeline: progress divider, stage index split, offset dividers,
// elapsed time and alive flag; uses pua_pkg.
`default_nettype none
module pua_atlas import pua_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] dt,
	input  wire logic [4:0]  rows,
	input  wire pua_in_t     item,
	output pua_atl_t         res
);

	typedef struct packed {
		logic [NW-1:0]    n;
		logic [IDX_W-1:0] last;
		logic             over;
		logic [31:0]      life;
		logic [31:0]      nel;
		logic             alive;
	} div_side_t;

	typedef struct packed {
		logic [NW-1:0] n;
		logic [31:0]   nel;
		logic          alive;
		logic [15:0]   bl;
	} off_side_t;

	// split a stage index into row and column by restoring division
	function automatic logic [2*RW-1:0] split_idx(input logic [IDX_W-1:0] i,
			input logic [NW-1:0] n);
		logic [NW:0]   r;
		logic [RW-1:0] q;
		r = (NW+1)'(i >> RW);
		for (int b = RW - 1; b >= 0; b--) begin
			r = {r[NW-1:0], i[b]};
			if (r >= {1'b0, n}) begin
				r    = r - {1'b0, n};
				q[b] = 1'b1;
			end else begin
				q[b] = 1'b0;
			end
		end
		return {q, RW'(r)};
	endfunction

	logic [NW-1:0]       n_c;
	logic [2*NW-1:0]     nn_c;
	logic [STG_W-1:0]    stg_c;
	logic [31+STG_W:0]   prod_c;
	logic [32:0]         nel_c;
	logic [31:0]         nel_sat_c;

	logic [31:0]         rem_s [Q_W+1];
	logic [Q_W-1:0]      low_s [Q_W+1];
	logic [Q_W-1:0]      q_s   [Q_W+1];
	div_side_t           dside_s [Q_W+1];

	logic [NW-1:0]       orem_s [OFF_STG+1][4];
	logic [15:0]         oq_s   [OFF_STG+1][4];
	off_side_t           oside_s [OFF_STG+1];

	always_comb begin
		if (rows == 5'd0)
			n_c = NW'(1);
		else if (32'(rows) > 32'(MAX_ATLAS_ROWS))
			n_c = NW'(MAX_ATLAS_ROWS);
		else
			n_c = NW'(rows);
		nn_c      = n_c * n_c;
		stg_c     = STG_W'(nn_c);
		prod_c    = item.elapsed_time * stg_c;
		nel_c     = {1'b0, item.elapsed_time} + {1'b0, dt};
		nel_sat_c = nel_c[32] ? '1 : nel_c[31:0];
	end

	// entry stage: product, saturated elapsed time, alive and over flags, first partial remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]         <= 32'(prod_c >> IDX_W);
			low_s[0]         <= {prod_c[IDX_W-1:0], 16'h0000};
			q_s[0]           <= '0;
			dside_s[0].n     <= n_c;
			dside_s[0].last  <= IDX_W'(stg_c - STG_W'(1));
			dside_s[0].over  <= (item.life_length == 32'd0) ||
				(item.elapsed_time >= item.life_length);
			dside_s[0].life  <= item.life_length;
			dside_s[0].nel   <= nel_sat_c;
			dside_s[0].alive <= nel_sat_c < item.life_length;
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < Q_W; k++) begin : g_div
		logic [32:0] t;
		logic        ge;
		always_comb begin
			t  = {rem_s[k], low_s[k][Q_W-1]};
			ge = t >= {1'b0, dside_s[k].life};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]   <= ge ? 32'(t - {1'b0, dside_s[k].life}) : t[31:0];
				low_s[k+1]   <= low_s[k] << 1;
				q_s[k+1]     <= {q_s[k][Q_W-2:0], ge};
				dside_s[k+1] <= dside_s[k];
			end
		end
	end

	// pick stages, blend and row/column of both stages
	logic [IDX_W-1:0] qi_c, i1_c, i2_c;
	logic [15:0]      bl_c;
	logic [2*RW-1:0]  rc1_c, rc2_c;
	div_side_t        ds_c;

	always_comb begin
		ds_c = dside_s[Q_W];
		qi_c = q_s[Q_W][Q_W-1:16];
		if (ds_c.over || qi_c > ds_c.last) begin
			i1_c = ds_c.last;
			bl_c = 16'h0000;
		end else begin
			i1_c = qi_c;
			bl_c = q_s[Q_W][15:0];
		end
		i2_c  = (i1_c < ds_c.last) ? i1_c + IDX_W'(1) : i1_c;
		rc1_c = split_idx(i1_c, ds_c.n);
		rc2_c = split_idx(i2_c, ds_c.n);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			orem_s[0][0]     <= NW'(rc1_c[RW-1:0]);
			orem_s[0][1]     <= NW'(rc1_c[2*RW-1:RW]);
			orem_s[0][2]     <= NW'(rc2_c[RW-1:0]);
			orem_s[0][3]     <= NW'(rc2_c[2*RW-1:RW]);
			for (int l = 0; l < 4; l++)
				oq_s[0][l] <= '0;
			oside_s[0].n     <= ds_c.n;
			oside_s[0].nel   <= ds_c.nel;
			oside_s[0].alive <= ds_c.alive;
			oside_s[0].bl    <= bl_c;
		end
	end

	// offsets: (row or column) * 2^16 / n, OFF_STEPS quotient bits per stage
	for (genvar s = 0; s < OFF_STG; s++) begin : g_off
		logic [NW-1:0] nrem [4];
		logic [15:0]   nq   [4];
		logic [NW:0]   t;
		always_comb begin
			t = '0;
			for (int l = 0; l < 4; l++) begin
				nrem[l] = orem_s[s][l];
				nq[l]   = oq_s[s][l];
				for (int b = 0; b < OFF_STEPS; b++) begin
					t = {nrem[l], 1'b0};
					if (t >= {1'b0, oside_s[s].n}) begin
						t     = t - {1'b0, oside_s[s].n};
						nq[l] = {nq[l][14:0], 1'b1};
					end else begin
						nq[l] = {nq[l][14:0], 1'b0};
					end
					nrem[l] = t[NW-1:0];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 4; l++) begin
					orem_s[s+1][l] <= nrem[l];
					oq_s[s+1][l]   <= nq[l];
				end
				oside_s[s+1] <= oside_s[s];
			end
		end
	end

	assign res.new_elapsed = oside_s[OFF_STG].nel;
	assign res.alive       = oside_s[OFF_STG].alive;
	assign res.tex1_u      = oq_s[OFF_STG][0];
	assign res.tex1_v      = oq_s[OFF_STG][1];
	assign res.tex2_u      = oq_s[OFF_STG][2];
	assign res.tex2_v      = oq_s[OFF_STG][3];
	assign res.blend       = oside_s[OFF_STG].bl;

endmodule
`default_nettype wire

FILE: rtl/particle_update_atlas_step.sv
// Top level: configuration registers, pipeline valid chain, output join.
// Depends on pua_pkg, pua_if, pua_motion and pua_atlas.
`default_nettype none
// Streams particle records, one item per clock unless the output stalls, and
// returns each record one frame later, in order. The depth is set by the
// atlas path: an entry stage, the stage-progress divider, which resolves one
// quotient bit per stage (24 stages), an index-split stage and four stages of
// atlas offset division; the kinematics and camera-distance path is shorter
// and is delayed to match. The whole pipeline advances together: when a
// result sits at the output and result.ready is low, particle.ready drops in
// the same cycle. Register writes are always taken and change every later
// item, so write them only while the pipeline is empty.
module particle_update_atlas_step import pua_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	pua_item_if.sink     particle,
	pua_result_if.source result,
	pua_cfg_if.sink      cfg
);

	logic [31:0]        dt_q;
	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic [4:0]         rows_q;
	logic [DEPTH-1:0]   vld_q;
	logic               en;
	pua_mot_t           mot_res;
	pua_atl_t           atl_res;
	pua_mot_t           mdly_s [PAD];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q    <= '0;
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			rows_q  <= 5'd1;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DELTA_TIME: dt_q    <= cfg.data;
				REG_CAMERA_X:   cam_x_q <= cfg.data;
				REG_CAMERA_Y:   cam_y_q <= cfg.data;
				REG_CAMERA_Z:   cam_z_q <= cfg.data;
				REG_ATLAS_ROWS: rows_q  <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	// advance everything unless the output holds an unaccepted item
	assign en             = !vld_q[DEPTH-1] || result.ready;
	assign particle.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], particle.valid};
		end
	end

	pua_motion u_motion (
		.clk   (clk),
		.en    (en),
		.dt    (dt_q),
		.cam_x (cam_x_q),
		.cam_y (cam_y_q),
		.cam_z (cam_z_q),
		.item  (particle.data),
		.res   (mot_res)
	);

	pua_atlas u_atlas (
		.clk  (clk),
		.en   (en),
		.dt   (dt_q),
		.rows (rows_q),
		.item (particle.data),
		.res  (atl_res)
	);

	// line up the shorter kinematics path with the divider path
	always_ff @(posedge clk) begin
		if (en) begin
			mdly_s[0] <= mot_res;
			for (int k = 1; k < PAD; k++)
				mdly_s[k] <= mdly_s[k-1];
		end
	end

	assign result.valid            = vld_q[DEPTH-1];
	assign result.data.new_pos_x   = mdly_s[PAD-1].new_pos_x;
	assign result.data.new_pos_y   = mdly_s[PAD-1].new_pos_y;
	assign result.data.new_pos_z   = mdly_s[PAD-1].new_pos_z;
	assign result.data.new_vel_y   = mdly_s[PAD-1].new_vel_y;
	assign result.data.distance_sq = mdly_s[PAD-1].distance_sq;
	assign result.data.new_elapsed = atl_res.new_elapsed;
	assign result.data.alive       = atl_res.alive;
	assign result.data.tex1_u      = atl_res.tex1_u;
	assign result.data.tex1_v      = atl_res.tex1_v;
	assign result.data.tex2_u      = atl_res.tex2_u;
	assign result.data.tex2_v      = atl_res.tex2_v;
	assign result.data.blend       = atl_res.blend;

endmodule
`default_nettype wire
